@@ hdl/eeio_pkg.sv @@
package eeio_pkg;

    localparam int DIV_STEPS = 34;
    localparam int SIN_STEPS = 4;
    localparam int EXP_STEPS = 8;
    localparam int CELL_LAT  = 3;

    localparam logic [16:0] ONE_Q16        = 17'd65536;
    localparam logic [30:0] ONE_Q30        = 31'd1073741824;
    localparam logic [30:0] HALF_PI_Q30    = 31'd1686629713;
    localparam logic [29:0] LN2_Q30        = 30'd744261118;
    localparam logic [17:0] DEFAULT_PERIOD = 18'd29491;
    localparam logic signed [19:0] OUT_MIN = -20'sd32768;
    localparam logic signed [19:0] OUT_MAX = 20'sd98304;

    typedef enum logic [1:0] {
        SP_NONE,
        SP_ZERO,
        SP_ONE
    } special_t;

    typedef struct packed {
        special_t           special;
        logic               n_neg;
        logic signed [17:0] u;
    } div_side_t;

    typedef struct packed {
        logic [17:0] rem;
        logic [33:0] dvd;
        logic [15:0] quo;
        logic [17:0] den;
        div_side_t   side;
    } div_word_t;

    typedef struct packed {
        special_t   special;
        logic       u_neg;
        logic       sneg;
        logic [3:0] ip;
    } tail_side_t;

    function automatic int sin_k(input int i);
        int k;
        case (i)
            0: k = 72;
            1: k = 42;
            2: k = 20;
            default: k = 6;
        endcase
        return k;
    endfunction

    function automatic int exp_k(input int i);
        return EXP_STEPS - i;
    endfunction

endpackage

@@ hdl/eeio_div_cell.sv @@
module eeio_div_cell (
    input  logic                 aclk,
    input  logic                 en,
    input  eeio_pkg::div_word_t  d_in,
    output eeio_pkg::div_word_t  d_out
);
    import eeio_pkg::*;

    div_word_t   d_reg;
    div_word_t   d_next;
    logic [18:0] trial;
    logic        ge;
    logic [18:0] diff;

    always_comb begin
        trial  = {d_in.rem, d_in.dvd[33]};
        ge     = trial >= {1'b0, d_in.den};
        diff   = trial - {1'b0, d_in.den};
        d_next = d_in;
        d_next.rem = ge ? diff[17:0] : trial[17:0];
        d_next.dvd = {d_in.dvd[32:0], 1'b0};
        d_next.quo = {d_in.quo[14:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

@@ hdl/eeio_horner_cell.sv @@
module eeio_horner_cell #(
    parameter int K = 1
) (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] x_in,
    input  logic [30:0] t_in,
    output logic [31:0] x_out,
    output logic [30:0] t_out
);
    import eeio_pkg::*;

    // floor(v/K) by reciprocal, estimate is low by at most one
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / K);
    localparam logic [35:0] K_W   = 36'(K);

    logic [31:0] x1_reg, x2_reg, x3_reg;
    logic [31:0] v1_reg, v2_reg, qe2_reg;
    logic [30:0] t3_reg;

    logic [62:0] xt;
    logic [64:0] vm;
    logic [35:0] qk;
    logic [35:0] rem;
    logic [31:0] q;
    logic [32:0] t_next;

    always_comb begin
        xt     = {31'd0, x_in} * {32'd0, t_in};
        vm     = {33'd0, v1_reg} * {32'd0, RECIP};
        qk     = {4'd0, qe2_reg} * K_W;
        rem    = {4'd0, v2_reg} - qk;
        q      = qe2_reg + {31'd0, (rem >= K_W)};
        t_next = {2'b0, ONE_Q30} - {1'b0, q};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg  <= x_in;
            v1_reg  <= xt[61:30];
            x2_reg  <= x1_reg;
            v2_reg  <= v1_reg;
            qe2_reg <= vm[63:32];
            x3_reg  <= x2_reg;
            t3_reg  <= t_next[30:0];
        end
    end

    assign x_out = x3_reg;
    assign t_out = t3_reg;

endmodule

@@ hdl/elastic_ease_in_out_top.sv @@
// Throughput: one item per cycle; the whole pipeline holds only while a
// result waits at the output. Latency is set by the 34-cell restoring
// divider chain, the 8-cell exp Horner chain (3 stages per cell) and tail.
// Reset (aresetn low, synchronous) clears the valid line and the period
// register and holds s_ready low; datapath registers are not reset.
module elastic_ease_in_out_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [16:0] s_phase,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [17:0] m_eased,
    input  logic        cfg_wr_en,
    input  logic [17:0] cfg_wr_data
);
    import eeio_pkg::*;

    localparam int T_IDX   = DIV_STEPS + 3;
    localparam int SIN_LAT = CELL_LAT * SIN_STEPS;
    localparam int EXP_LAT = CELL_LAT * EXP_STEPS;
    localparam int SM_D    = EXP_LAT - SIN_LAT;
    localparam int SD_LEN  = EXP_LAT + 3;
    localparam int LAT     = T_IDX + EXP_LAT + 4;

    logic           en;
    logic [LAT-1:0] vld_reg;
    logic [17:0]    period_reg;

    assign en      = !m_valid || m_ready;
    assign s_ready = aresetn && en;
    assign m_valid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            period_reg <= '0;
        end else begin
            if (en) begin
                vld_reg <= {vld_reg[LAT-2:0], s_valid};
            end
            if (cfg_wr_en) begin
                period_reg <= cfg_wr_data;
            end
        end
    end

    // prep
    logic [17:0]        p_eff;
    logic signed [18:0] u_w;
    logic signed [19:0] n_w;
    logic [19:0]        mag_w;
    div_word_t          div_in;
    div_word_t          div_q [0:DIV_STEPS];

    always_comb begin
        p_eff = (period_reg == 18'd0) ? DEFAULT_PERIOD : period_reg;
        u_w   = $signed({1'b0, s_phase, 1'b0}) - 19'sd65536;
        n_w   = $signed({u_w[18], u_w}) - $signed({4'b0, p_eff[17:2]});
        mag_w = n_w[19] ? 20'(-n_w) : 20'(n_w);
        div_in.rem        = '0;
        div_in.dvd        = {mag_w[17:0], 16'd0};
        div_in.quo        = '0;
        div_in.den        = p_eff;
        div_in.side.n_neg = n_w[19];
        div_in.side.u     = u_w[17:0];
        if (s_phase == 17'd0) begin
            div_in.side.special = SP_ZERO;
        end else if (s_phase >= ONE_Q16) begin
            div_in.side.special = SP_ONE;
        end else begin
            div_in.side.special = SP_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            div_q[0] <= div_in;
        end
    end

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
        eeio_div_cell u_cell (
            .aclk  (aclk),
            .en    (en),
            .d_in  (div_q[i]),
            .d_out (div_q[i+1])
        );
    end

    // turn and exponent split
    div_word_t   dl;
    logic [15:0] q_adj;
    logic [15:0] turn;
    logic [14:0] f_w;
    logic [17:0] u_abs;
    logic [21:0] e_w;
    tail_side_t  tr_side;

    logic [14:0] f_reg;
    logic [15:0] ef_reg;
    tail_side_t  tr_reg;

    always_comb begin
        dl    = div_q[DIV_STEPS];
        q_adj = dl.quo + {15'd0, (dl.rem != 18'd0)};
        turn  = dl.side.n_neg ? (16'd0 - q_adj) : dl.quo;
        f_w   = turn[14] ? (15'd16384 - {1'b0, turn[13:0]}) : {1'b0, turn[13:0]};
        u_abs = dl.side.u[17] ? 18'(-dl.side.u) : 18'(dl.side.u);
        e_w   = {4'd0, u_abs} * 22'd10;
        tr_side.special = dl.side.special;
        tr_side.u_neg   = dl.side.u[17];
        tr_side.sneg    = turn[15];
        tr_side.ip      = e_w[19:16];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_reg  <= f_w;
            ef_reg <= e_w[15:0];
            tr_reg <= tr_side;
        end
    end

    // angle and exp argument
    logic [45:0] r_prod;
    logic [45:0] y_prod;
    logic [30:0] r_reg;
    logic [29:0] y_reg;
    tail_side_t  m1_reg;

    always_comb begin
        r_prod = {31'd0, f_reg} * {15'd0, HALF_PI_Q30};
        y_prod = {30'd0, ef_reg} * {16'd0, LN2_Q30};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg  <= r_prod[44:14];
            y_reg  <= y_prod[45:16];
            m1_reg <= tr_reg;
        end
    end

    // r squared
    logic [61:0] rr_prod;
    logic [31:0] r2_reg;
    logic [29:0] yt_reg;
    logic [30:0] rd_reg [0:SIN_LAT];
    tail_side_t  sd_reg [0:SD_LEN-1];

    assign rr_prod = {31'd0, r_reg} * {31'd0, r_reg};

    always_ff @(posedge aclk) begin
        if (en) begin
            r2_reg    <= rr_prod[61:30];
            yt_reg    <= y_reg;
            rd_reg[0] <= r_reg;
            sd_reg[0] <= m1_reg;
            for (int i = 1; i <= SIN_LAT; i++) begin
                rd_reg[i] <= rd_reg[i-1];
            end
            for (int i = 1; i < SD_LEN; i++) begin
                sd_reg[i] <= sd_reg[i-1];
            end
        end
    end

    logic [31:0] sx [0:SIN_STEPS];
    logic [30:0] st [0:SIN_STEPS];
    logic [31:0] ex [0:EXP_STEPS];
    logic [30:0] et [0:EXP_STEPS];

    assign sx[0] = r2_reg;
    assign st[0] = ONE_Q30;
    assign ex[0] = {2'b0, yt_reg};
    assign et[0] = ONE_Q30;

    for (genvar i = 0; i < SIN_STEPS; i++) begin : g_sin
        eeio_horner_cell #(.K(sin_k(i))) u_cell (
            .aclk  (aclk),
            .en    (en),
            .x_in  (sx[i]),
            .t_in  (st[i]),
            .x_out (sx[i+1]),
            .t_out (st[i+1])
        );
    end

    for (genvar i = 0; i < EXP_STEPS; i++) begin : g_exp
        eeio_horner_cell #(.K(exp_k(i))) u_cell (
            .aclk  (aclk),
            .en    (en),
            .x_in  (ex[i]),
            .t_in  (et[i]),
            .x_out (ex[i+1]),
            .t_out (et[i+1])
        );
    end

    // sine magnitude, held until exp is done
    logic [61:0] sm_prod;
    logic [30:0] smd_reg [0:SM_D];

    assign sm_prod = {31'd0, rd_reg[SIN_LAT]} * {31'd0, st[SIN_STEPS]};

    always_ff @(posedge aclk) begin
        if (en) begin
            smd_reg[0] <= sm_prod[60:30];
            for (int i = 1; i <= SM_D; i++) begin
                smd_reg[i] <= smd_reg[i-1];
            end
        end
    end

    // tail
    logic [30:0] ex_reg;
    logic [16:0] prod_reg;
    logic [17:0] eased_reg;
    logic [62:0] half_prod;
    tail_side_t  os;
    logic signed [19:0] pv;
    logic signed [19:0] res;

    assign half_prod = ({32'd0, ex_reg} * {32'd0, smd_reg[SM_D]}) + (63'd1 << 44);

    always_comb begin
        os = sd_reg[SD_LEN-1];
        pv = $signed({3'b0, prod_reg});
        if (os.u_neg) begin
            res = os.sneg ? pv : -pv;
        end else begin
            res = $signed({3'b0, ONE_Q16}) + (os.sneg ? -pv : pv);
        end
        case (os.special)
            SP_ZERO: res = 20'sd0;
            SP_ONE:  res = $signed({3'b0, ONE_Q16});
            default: ;
        endcase
        if (res < OUT_MIN) begin
            res = OUT_MIN;
        end
        if (res > OUT_MAX) begin
            res = OUT_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ex_reg    <= et[EXP_STEPS] >> sd_reg[EXP_LAT].ip;
            prod_reg  <= half_prod[61:45];
            eased_reg <= res[17:0];
        end
    end

    assign m_eased = eased_reg;

    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ($signed(m_eased) >= -18'sd32768))
        else $error("eased below range");

    a_out_top: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ($signed({2'b0, m_eased[16:0]}) <= 19'sd98304 || m_eased[17]))
        else $error("eased above range");

    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        en && vld_reg[LAT-2] |=> m_valid)
        else $error("valid lost in pipeline");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> vld_reg == $past(vld_reg))
        else $error("pipeline moved while stalled");

endmodule
